// File: rtl/tsr_pkg.sv
// Shared constants for the transport stream sync and PID router.
package tsr_pkg;

	localparam int PKT_LEN         = 188;
	localparam int WIN_AW          = 8;
	localparam int PID_W           = 13;
	localparam int PID_COUNT       = 1 << PID_W;
	localparam int DEF_NUM_FILTERS = 8;
	localparam int ROUTE_W         = 8;

	localparam logic [7:0] SYNC_BYTE = 8'h47;

	localparam logic [1:0] CMD_STREAM = 2'd0;
	localparam logic [1:0] CMD_SET    = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] MODE_HUNT   = 2'd0;
	localparam logic [1:0] MODE_LOCKED = 2'd1;
	localparam logic [1:0] MODE_SKIP   = 2'd2;

endpackage

// File: rtl/tsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/ts_packet_sync_pid_router_unit.sv
// Top level of the transport stream sync and PID router.
//
// Input items (s_*): tuser carries the command; tdata carries data_byte,
// filter_index and pid. Stream bytes fill a 188-byte window; once sync is
// found, each packet byte leaves one packet later on the output (m_*) with
// the route mask of its packet, start/last markers and the packet flags.
// Set commands mark one PID of one filter; clear commands wipe one filter.
//
// Sequencing, set by the single read port of the window RAM and the FSM around it:
// a byte that only fills the window is taken in IDLE, a dropped byte passes
// IDLE and OLD, a byte in mid-packet IDLE, OLD and EMIT, a sync byte IDLE, OLD,
// LAT1, LAT2, LAT3 and EMIT (three window reads for bytes 1..3 plus one PID
// bitmap read). A set command is taken in IDLE; a clear command walks CLEAR,
// one bitmap entry per cycle. After reset all 8192 bitmap entries are cleared with
// s_tready low. A stalled receiver holds the result in the output register;
// the next item is still accepted and its result waits for the register.
module ts_packet_sync_pid_router_unit
	import tsr_pkg::*;
#(
	parameter int NUM_FILTERS = DEF_NUM_FILTERS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // data_byte[7:0], filter_index[10:8], pid[23:11]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // out_byte[7:0], route_mask[15:8]
	output logic [2:0]  m_tuser,  // packet_start[0], transport_error[1], scrambled[2]
	output logic        m_tlast   // packet_last
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_OLD   = 3'd2;
	localparam logic [2:0] ST_LAT1  = 3'd3;
	localparam logic [2:0] ST_LAT2  = 3'd4;
	localparam logic [2:0] ST_LAT3  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;
	localparam logic [2:0] ST_CLEAR = 3'd7;

	localparam logic [WIN_AW-1:0] LAST_POS = WIN_AW'(PKT_LEN - 1);
	localparam logic [PID_W-1:0]  LAST_PID = PID_W'(PID_COUNT - 1);

	logic [2:0]        state_q;
	logic [WIN_AW-1:0] head_q;
	logic [WIN_AW-1:0] fill_q;
	logic [WIN_AW-1:0] pos_q;
	logic [1:0]        mode_q;
	logic [PID_W-1:0]  clr_q;
	logic [2:0]        fidx_q;
	logic [7:0]        data_q;
	logic [7:0]        oldest_q;
	logic [7:0]        b1_q;
	logic [ROUTE_W-1:0] route_q;
	logic              terr_q;
	logic              scr_q;

	logic [7:0]         out_byte_q;
	logic [ROUTE_W-1:0] out_route_q;
	logic               out_start_q;
	logic               out_last_q;
	logic               out_terr_q;
	logic               out_scr_q;
	logic               out_valid_q;

	logic [7:0]        in_data;
	logic [2:0]        in_fidx;
	logic [PID_W-1:0]  in_pid;
	logic              in_acc;
	logic              out_free;
	logic              win_full;

	logic              win_we;
	logic [WIN_AW-1:0] win_waddr;
	logic [7:0]        win_wdata;
	logic [WIN_AW-1:0] win_raddr;
	logic [7:0]        win_rdata;

	logic [NUM_FILTERS-1:0] bm_we;
	logic [PID_W-1:0]       bm_waddr;
	logic                   bm_wdata;
	logic [PID_W-1:0]       bm_raddr;
	logic [NUM_FILTERS-1:0] bm_rdata;
	logic [ROUTE_W-1:0]     route_next;

	logic              start;
	logic              emit;
	logic [WIN_AW-1:0] head_next;

	function automatic logic [WIN_AW-1:0] win_off(input logic [WIN_AW-1:0] base,
	                                             input logic [1:0] off);
		logic [WIN_AW:0] sum;
		sum = {1'b0, base} + {{(WIN_AW-1){1'b0}}, off};
		if (sum >= (WIN_AW+1)'(PKT_LEN)) begin
			sum = sum - (WIN_AW+1)'(PKT_LEN);
		end
		return sum[WIN_AW-1:0];
	endfunction

	assign in_data  = s_tdata[7:0];
	assign in_fidx  = s_tdata[10:8];
	assign in_pid   = s_tdata[23:11];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign win_full = (fill_q == WIN_AW'(PKT_LEN));
	assign head_next = (head_q == LAST_POS) ? '0 : head_q + 1'b1;

	always_comb begin
		start = 1'b0;
		emit  = 1'b0;
		case (mode_q)
			MODE_HUNT: start = (win_rdata == SYNC_BYTE) && (data_q == SYNC_BYTE);
			MODE_SKIP: start = (win_rdata == SYNC_BYTE);
			MODE_LOCKED: begin
				if (pos_q == '0) begin
					start = (win_rdata == SYNC_BYTE);
				end else begin
					emit = 1'b1;
				end
			end
			default: start = 1'b0;
		endcase
	end

	always_comb begin
		win_we    = 1'b0;
		win_waddr = head_q;
		win_wdata = data_q;
		case (state_q)
			ST_IDLE: begin
				win_waddr = fill_q;
				win_wdata = in_data;
				win_we    = in_acc && (s_tuser == CMD_STREAM) && !win_full;
			end
			ST_OLD:  win_we = !start && !emit;
			ST_EMIT: win_we = out_free;
			default: win_we = 1'b0;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_OLD:  win_raddr = win_off(head_q, 2'd1);
			ST_LAT1: win_raddr = win_off(head_q, 2'd2);
			ST_LAT2: win_raddr = win_off(head_q, 2'd3);
			default: win_raddr = head_q;
		endcase
	end

	tsr_ram #(
		.WIDTH(8),
		.DEPTH(PKT_LEN)
	) u_win_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (win_waddr),
		.wdata (win_wdata),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	assign bm_waddr = (state_q == ST_IDLE) ? in_pid : clr_q;
	assign bm_wdata = (state_q == ST_IDLE);
	assign bm_raddr = {b1_q[4:0], win_rdata};

	for (genvar f = 0; f < NUM_FILTERS; f++) begin : g_bm
		assign bm_we[f] = (state_q == ST_INIT)
			|| ((state_q == ST_CLEAR) && (32'(fidx_q) == f))
			|| (in_acc && (s_tuser == CMD_SET) && (32'(in_fidx) == f));

		tsr_ram #(
			.WIDTH(1),
			.DEPTH(PID_COUNT)
		) u_bm_ram (
			.clk   (clk),
			.we    (bm_we[f]),
			.waddr (bm_waddr),
			.wdata (bm_wdata),
			.raddr (bm_raddr),
			.rdata (bm_rdata[f])
		);
	end

	for (genvar g = 0; g < ROUTE_W; g++) begin : g_route
		if (g < NUM_FILTERS) begin : g_on
			assign route_next[g] = bm_rdata[g];
		end else begin : g_off
			assign route_next[g] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			head_q      <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			mode_q      <= MODE_HUNT;
			clr_q       <= '0;
			route_q     <= '0;
			terr_q      <= 1'b0;
			scr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= ((state_q == ST_EMIT) && out_free) || (out_valid_q && !m_tready);
			case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_PID) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (s_tuser)
							CMD_STREAM: begin
								if (!win_full) begin
									fill_q <= fill_q + 1'b1;
								end else begin
									state_q <= ST_OLD;
								end
							end
							CMD_CLEAR: begin
								if (32'(in_fidx) < NUM_FILTERS) begin
									clr_q   <= '0;
									state_q <= ST_CLEAR;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_PID) begin
						state_q <= ST_IDLE;
					end
				end
				ST_OLD: begin
					if (start) begin
						mode_q  <= MODE_LOCKED;
						pos_q   <= '0;
						state_q <= ST_LAT1;
					end else if (emit) begin
						state_q <= ST_EMIT;
					end else begin
						if ((mode_q == MODE_LOCKED) && (pos_q == '0)) begin
							mode_q <= MODE_SKIP;
						end
						head_q  <= head_next;
						state_q <= ST_IDLE;
					end
				end
				ST_LAT1: state_q <= ST_LAT2;
				ST_LAT2: state_q <= ST_LAT3;
				ST_LAT3: begin
					route_q <= route_next;
					terr_q  <= b1_q[7];
					scr_q   <= (win_rdata[7:6] != 2'b00);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						pos_q       <= (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
						head_q      <= head_next;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_q <= in_data;
			fidx_q <= in_fidx;
		end
		if (state_q == ST_OLD) begin
			oldest_q <= win_rdata;
		end
		if (state_q == ST_LAT1) begin
			b1_q <= win_rdata;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			out_byte_q  <= oldest_q;
			out_route_q <= route_q;
			out_start_q <= (pos_q == '0);
			out_last_q  <= (pos_q == LAST_POS);
			out_terr_q  <= terr_q;
			out_scr_q   <= scr_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_route_q, out_byte_q};
	assign m_tuser  = {out_scr_q, out_terr_q, out_start_q};
	assign m_tlast  = out_last_q;

	a_start_is_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_start_q) |-> (out_byte_q == SYNC_BYTE))
		else $error("packet start without sync byte");

	a_start_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_start_q && out_last_q))
		else $error("packet start and last on one item");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= LAST_POS) && (pos_q <= LAST_POS) && (fill_q <= WIN_AW'(PKT_LEN)))
		else $error("window pointer out of range");

	a_head_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q != $past(head_q)) |-> win_full)
		else $error("head moved before window filled");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3)
		else $error("illegal sync mode");

endmodule
